// ===== hdl/ldrt_pkg.sv =====
// Shared constants for the longest distinct run tracker.
// No dependencies; used by the top level.
package ldrt_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned LenW   = 7;

endpackage

// ===== hdl/ldrt_cell.sv =====
// One window cell: holds one stored word, shifts it on to the next cell
// and compares it against the incoming key. No package dependencies.
module ldrt_cell #(
  parameter int unsigned ValueBits = 32,
  parameter int unsigned RunW      = 7,
  parameter int unsigned Index     = 0
) (
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  logic [ValueBits-1:0] data_i,
  input  logic [ValueBits-1:0] key_i,
  input  logic [RunW-1:0]      run_i,
  output logic [ValueBits-1:0] data_o,
  output logic                 match_o
);

  logic [ValueBits-1:0] value_q;
  logic [ValueBits-1:0] value_d;
  logic                 live;

  // cells below the run length hold live entries (cell 0 is the newest)
  assign live    = RunW'(Index) < run_i;
  assign match_o = live && (value_q == key_i);
  assign data_o  = value_q;
  assign value_d = shift_i ? data_i : value_q;

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== hdl/longest_distinct_run_tracker_unit.sv =====
// The result word is registered directly from the input word as it is taken.
// Throughput: one word per cycle; the cell chain compares every window entry
// in the same cycle and shifts the new word in as the words are taken.
// A result waiting in the output register stalls the input side until it is taken.
// Reset clears run length, maximum, overflow and output valid; window empty.
module longest_distinct_run_tracker_unit #(
  parameter int unsigned WINDOW     = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ldrt_pkg::ValueW-1:0]   value_i,
  input  logic                          start_new_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ldrt_pkg::LenW-1:0]     run_length_o,
  output logic [ldrt_pkg::LenW-1:0]     max_length_o,
  output logic                          overflow_o
);

  localparam int unsigned RunW = $clog2(WINDOW + 1);
  localparam int unsigned IdxW = $clog2(WINDOW);
  localparam int unsigned LenW = ldrt_pkg::LenW;

  logic [VALUE_BITS-1:0] key;
  logic                  accept;

  logic [RunW-1:0] run_q, run_d, run_base, run_new;
  logic [RunW-1:0] best_q, best_d, best_base;
  logic            ovf_q, ovf_d, ovf_base;
  logic            out_valid_q, out_valid_d;

  logic [LenW-1:0] run_len_q, run_len_d;
  logic [LenW-1:0] max_len_q, max_len_d;
  logic            ovf_out_q, ovf_out_d;

  logic [VALUE_BITS-1:0] chain [WINDOW+1];
  logic [WINDOW-1:0]     match;
  logic                  hit;
  logic [IdxW-1:0]       hit_idx;

  logic [LenW+RunW-1:0] run_ext, best_ext;

  generate
    if (VALUE_BITS <= ldrt_pkg::ValueW) begin : g_key_narrow
      assign key = value_i[VALUE_BITS-1:0];
    end else begin : g_key_wide
      assign key = {{(VALUE_BITS - ldrt_pkg::ValueW){1'b0}}, value_i};
    end
  endgenerate

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // start word: compare against an empty window
  assign run_base  = start_new_i ? '0 : run_q;
  assign best_base = start_new_i ? '0 : best_q;
  assign ovf_base  = start_new_i ? 1'b0 : ovf_q;

  assign chain[0] = key;

  for (genvar j = 0; j < WINDOW; j++) begin : g_cell
    ldrt_cell #(
      .ValueBits(VALUE_BITS),
      .RunW     (RunW),
      .Index    (j)
    ) u_cell (
      .clk_i  (clk_i),
      .shift_i(accept),
      .data_i (chain[j]),
      .key_i  (key),
      .run_i  (run_base),
      .data_o (chain[j+1]),
      .match_o(match[j])
    );
  end

  // entries are distinct, so at most one cell matches
  always_comb begin
    hit_idx = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (match[j]) begin
        hit_idx = hit_idx | IdxW'(j);
      end
    end
  end

  assign hit = |match;

  always_comb begin
    ovf_d = ovf_base;
    if (hit) begin
      run_new = RunW'(hit_idx) + RunW'(1);
    end else if (run_base == RunW'(WINDOW)) begin
      run_new = run_base;
      ovf_d   = 1'b1;
    end else begin
      run_new = run_base + RunW'(1);
    end
    best_d = (run_new > best_base) ? run_new : best_base;
  end

  assign run_d = run_new;

  assign run_ext  = {{LenW{1'b0}}, run_new};
  assign best_ext = {{LenW{1'b0}}, best_d};

  assign run_len_d = accept ? run_ext[LenW-1:0]  : run_len_q;
  assign max_len_d = accept ? best_ext[LenW-1:0] : max_len_q;
  assign ovf_out_d = accept ? ovf_d : ovf_out_q;

  assign out_valid_d = accept ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        run_q  <= run_d;
        best_q <= best_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    run_len_q <= run_len_d;
    max_len_q <= max_len_d;
    ovf_out_q <= ovf_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign run_length_o = run_len_q;
  assign max_length_o = max_len_q;
  assign overflow_o   = ovf_out_q;

endmodule
